[sv/csi_capture_frame_builder_defines.svh]
// Assertion macros for the capture frame builder.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef CSI_CAPTURE_FRAME_BUILDER_DEFINES_SVH
`define CSI_CAPTURE_FRAME_BUILDER_DEFINES_SVH

// ante implies cons in the same cycle
`define CSICFB_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// cond never holds
`define CSICFB_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

[sv/csicfb_pkg.sv]
// Package for the capture frame builder: queue entry type, config type,
// frame constants and the channel-to-frequency function. No dependencies.
`default_nettype none

package csicfb_pkg;

  localparam int HDR_BYTES = 20;

  localparam logic [7:0]  PREFIX_0    = 8'hAB;
  localparam logic [7:0]  PREFIX_1    = 8'hCD;
  localparam logic [31:0] FRAME_MAGIC = 32'hC511_0001;
  localparam logic [7:0]  ANT_COUNT   = 8'd1;

  // config register indexes
  localparam logic [1:0] CFG_NODE_NUMBER = 2'd0;
  localparam logic [1:0] CFG_MIN_GAP_MS  = 2'd1;
  localparam logic [1:0] CFG_SERIAL_WRAP = 2'd2;

  localparam logic [7:0]  NODE_RST = 8'd0;
  localparam logic [15:0] GAP_RST  = 16'd20;
  localparam logic        WRAP_RST = 1'b1;

  // byte positions within a serialized frame entry
  localparam logic [4:0] IDX_PREFIX  = 5'd0;
  localparam logic [4:0] IDX_MAGIC   = 5'd4;
  localparam logic [4:0] IDX_HDR_END = 5'd23;
  localparam logic [4:0] IDX_PAYLOAD = 5'd24;

  localparam logic [7:0]  CH_24_LO  = 8'd1;
  localparam logic [7:0]  CH_24_HI  = 8'd13;
  localparam logic [7:0]  CH_14     = 8'd14;
  localparam logic [7:0]  CH_5_LO   = 8'd36;
  localparam logic [7:0]  CH_5_HI   = 8'd177;
  localparam logic [15:0] FREQ_24_OFS = 16'(2412 - 5);
  localparam logic [15:0] FREQ_CH14   = 16'd2484;
  localparam logic [15:0] FREQ_5_OFS  = 16'd5000;

  typedef struct packed {
    logic [7:0]  node;
    logic [15:0] min_gap;
    logic        wrap;
  } cfg_t;

  typedef struct packed {
    logic               hdr_vld;
    logic               pay_vld;
    logic               pay_end;
    logic [7:0]         pay_byte;
    logic               wrap;
    logic [7:0]         node;
    logic [15:0]        flen;
    logic [15:0]        sub;
    logic [15:0]        freq;
    logic [31:0]        seq;
    logic signed [7:0]  rssi;
    logic signed [7:0]  noise;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [15:0] chan_freq(input logic [7:0] ch);
    logic [15:0] ch5;
    ch5 = {6'd0, ch, 2'd0} + {8'd0, ch};
    if (ch >= CH_24_LO && ch <= CH_24_HI) begin
      chan_freq = FREQ_24_OFS + ch5;
    end else if (ch == CH_14) begin
      chan_freq = FREQ_CH14;
    end else if (ch >= CH_5_LO && ch <= CH_5_HI) begin
      chan_freq = FREQ_5_OFS + ch5;
    end else begin
      chan_freq = 16'd0;
    end
  endfunction

endpackage

`default_nettype wire

[sv/csicfb_if.sv]
// Channel interfaces of the capture frame builder: input items, framed
// output bytes and config writes. No dependencies.
`default_nettype none

interface csicfb_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        iq_byte;
  logic              first_byte;
  logic              final_byte;
  logic [15:0]       capture_len;
  logic signed [7:0] rssi_dbm;
  logic signed [7:0] noise_level;
  logic [7:0]        channel;
  logic [31:0]       time_ms;

  modport source(output valid, iq_byte, first_byte, final_byte, capture_len, rssi_dbm,
                 noise_level, channel, time_ms, input ready);
  modport sink(input valid, iq_byte, first_byte, final_byte, capture_len, rssi_dbm,
               noise_level, channel, time_ms, output ready);
endinterface

interface csicfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source(output valid, out_byte, frame_end, input ready);
  modport sink(input valid, out_byte, frame_end, output ready);
endinterface

interface csicfb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/csicfb_front.sv]
// Front end: accepts capture items, applies drop / rate-limit / clamp rules
// and pushes header and payload commands. Depends on csicfb_pkg, csicfb_if.
`default_nettype none

module csicfb_front #(
  parameter int MAX_FRAME_BYTES = 1500
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  csicfb_in_if.sink             in_i,
  input  csicfb_pkg::cfg_t      cfg_i,
  input  csicfb_pkg::fifo_stat_t stat_i,
  output logic                  push_o,
  output csicfb_pkg::entry_t    entry_o
);

  localparam int PayCap = MAX_FRAME_BYTES - csicfb_pkg::HDR_BYTES;
  localparam int LenW   = $clog2(PayCap + 1);
  localparam logic [15:0] PayCap16 = 16'(PayCap);

  logic [31:0]     last_ms_q, last_ms_d;
  logic [31:0]     seq_q, seq_d;
  logic            open_q, open_d;
  logic [LenW-1:0] left_q, left_d;
  logic            skip_q, skip_d;

  logic            accept;
  logic [31:0]     elapsed;
  logic            drop;
  logic [15:0]     plen;
  csicfb_pkg::entry_t cmd;

  assign in_i.ready = !stat_i.full;
  assign accept     = in_i.valid && in_i.ready;

  assign elapsed = in_i.time_ms - last_ms_q;
  assign drop    = (in_i.capture_len == 16'd0) || (elapsed < {16'd0, cfg_i.min_gap});
  assign plen    = (in_i.capture_len < PayCap16) ? in_i.capture_len : PayCap16;

  always_comb begin
    logic [LenW-1:0] left_v;
    logic            open_v;
    logic            skip_v;
    last_ms_d = last_ms_q;
    seq_d     = seq_q;
    open_v    = open_q;
    left_v    = left_q;
    skip_v    = skip_q;

    cmd          = '0;
    cmd.wrap     = cfg_i.wrap;
    cmd.node     = cfg_i.node;
    cmd.flen     = 16'(csicfb_pkg::HDR_BYTES) + plen;
    cmd.sub      = {1'b0, plen[15:1]};
    cmd.freq     = csicfb_pkg::chan_freq(in_i.channel);
    cmd.seq      = seq_q;
    cmd.rssi     = in_i.rssi_dbm;
    cmd.noise    = in_i.noise_level;
    cmd.pay_byte = in_i.iq_byte;

    // a first item always abandons whatever frame was open
    if (in_i.first_byte) begin
      open_v = 1'b0;
      left_v = '0;
      skip_v = 1'b0;
      if (drop) begin
        skip_v = 1'b1;
      end else begin
        last_ms_d   = in_i.time_ms;
        seq_d       = seq_q + 32'd1;
        open_v      = 1'b1;
        left_v      = plen[LenW-1:0];
        cmd.hdr_vld = 1'b1;
      end
    end

    if (skip_v) begin
      if (in_i.final_byte) begin
        skip_v = 1'b0;
      end
    end else if (open_v && (left_v != '0)) begin
      left_v      = left_v - LenW'(1);
      cmd.pay_vld = 1'b1;
      cmd.pay_end = (left_v == '0) || in_i.final_byte;
      if (cmd.pay_end) begin
        open_v = 1'b0;
        left_v = '0;
      end
    end else if (in_i.final_byte) begin
      open_v = 1'b0;
      left_v = '0;
    end

    open_d = open_v;
    left_d = left_v;
    skip_d = skip_v;
  end

  assign push_o  = accept && (cmd.hdr_vld || cmd.pay_vld);
  assign entry_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_ms_q <= '0;
      seq_q     <= '0;
      open_q    <= 1'b0;
      left_q    <= '0;
      skip_q    <= 1'b0;
    end else if (accept) begin
      last_ms_q <= last_ms_d;
      seq_q     <= seq_d;
      open_q    <= open_d;
      left_q    <= left_d;
      skip_q    <= skip_d;
    end
  end

endmodule

`default_nettype wire

[sv/csicfb_fifo.sv]
// Short command queue between front and back end, flop based, with
// full/empty status. Depends on csicfb_pkg.
`default_nettype none

module csicfb_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  csicfb_pkg::entry_t     wdata_i,
  input  logic                   pop_i,
  output csicfb_pkg::entry_t     rdata_o,
  output csicfb_pkg::fifo_stat_t stat_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  csicfb_pkg::entry_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == Full);
  assign stat_o.empty = (cnt_q == '0);
  assign rdata_o      = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

[sv/csicfb_back.sv]
// Back end: serializes queued commands into prefix, header and payload
// bytes through an output register. Depends on csicfb_pkg, csicfb_if.
`default_nettype none

module csicfb_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  csicfb_pkg::entry_t     rdata_i,
  input  csicfb_pkg::fifo_stat_t stat_i,
  output logic                   pop_o,
  csicfb_out_if.source           out_o
);

  csicfb_pkg::entry_t cur_q, cur_d;
  logic       cur_vld_q, cur_vld_d;
  logic [4:0] idx_q, idx_d;
  logic       out_vld_q, out_vld_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_end_q, out_end_d;

  logic       adv;
  logic       emit;
  logic       cur_done;
  logic [4:0] last_idx;
  logic [4:0] start_idx;
  logic [7:0] sel;
  logic       sel_end;

  assign adv       = !out_vld_q || out_o.ready;
  assign emit      = adv && cur_vld_q;
  assign last_idx  = cur_q.pay_vld ? csicfb_pkg::IDX_PAYLOAD : csicfb_pkg::IDX_HDR_END;
  assign cur_done  = emit && (idx_q == last_idx);
  assign pop_o     = !stat_i.empty && (!cur_vld_q || cur_done);
  assign start_idx = !rdata_i.hdr_vld ? csicfb_pkg::IDX_PAYLOAD :
                     rdata_i.wrap     ? csicfb_pkg::IDX_PREFIX  : csicfb_pkg::IDX_MAGIC;

  // byte at the current position; header fields are little-endian
  always_comb begin
    sel     = 8'd0;
    sel_end = 1'b0;
    unique case (idx_q)
      5'd0:         sel = csicfb_pkg::PREFIX_0;
      5'd1:         sel = csicfb_pkg::PREFIX_1;
      5'd2:         sel = cur_q.flen[15:8];
      5'd3:         sel = cur_q.flen[7:0];
      5'd4:         sel = csicfb_pkg::FRAME_MAGIC[7:0];
      5'd5:         sel = csicfb_pkg::FRAME_MAGIC[15:8];
      5'd6:         sel = csicfb_pkg::FRAME_MAGIC[23:16];
      5'd7:         sel = csicfb_pkg::FRAME_MAGIC[31:24];
      5'd8:         sel = cur_q.node;
      5'd9:         sel = csicfb_pkg::ANT_COUNT;
      5'd10:        sel = cur_q.sub[7:0];
      5'd11:        sel = cur_q.sub[15:8];
      5'd12:        sel = cur_q.freq[7:0];
      5'd13:        sel = cur_q.freq[15:8];
      5'd16:        sel = cur_q.seq[7:0];
      5'd17:        sel = cur_q.seq[15:8];
      5'd18:        sel = cur_q.seq[23:16];
      5'd19:        sel = cur_q.seq[31:24];
      5'd20:        sel = $unsigned(cur_q.rssi);
      5'd21:        sel = $unsigned(cur_q.noise);
      5'd24: begin
        sel     = cur_q.pay_byte;
        sel_end = cur_q.pay_end;
      end
      default:      sel = 8'd0;  // upper frequency bytes, reserved bytes
    endcase
  end

  always_comb begin
    cur_d     = cur_q;
    cur_vld_d = cur_vld_q;
    idx_d     = idx_q;
    if (pop_o) begin
      cur_d     = rdata_i;
      cur_vld_d = 1'b1;
      idx_d     = start_idx;
    end else if (cur_done) begin
      cur_vld_d = 1'b0;
    end else if (emit) begin
      idx_d = idx_q + 5'd1;
    end
  end

  always_comb begin
    out_vld_d  = out_vld_q;
    out_byte_d = out_byte_q;
    out_end_d  = out_end_q;
    if (emit) begin
      out_vld_d  = 1'b1;
      out_byte_d = sel;
      out_end_d  = sel_end;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.frame_end = out_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cur_vld_q <= cur_vld_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_byte_q <= out_byte_d;
    out_end_q  <= out_end_d;
  end

endmodule

`default_nettype wire

[sv/csi_capture_frame_builder.sv]
// A payload byte passes through the command queue and the current-command
// register to the output register. Throughput: one payload byte per cycle while
// out_o is ready; an accepted capture start adds 24 output bytes (20 without
// the prefix). The input stalls only when the 4-entry command queue fills.
// Reset: async active low; clears state and queue, config to its reset values.
// Depends on csicfb_pkg, csicfb_if, csicfb_front, csicfb_fifo, csicfb_back.
`default_nettype none
`include "csi_capture_frame_builder_defines.svh"

module csi_capture_frame_builder #(
  parameter int MAX_FRAME_BYTES = 1500,
  parameter int FIFO_DEPTH      = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  csicfb_cfg_if.sink   cfg_i,
  csicfb_in_if.sink    in_i,
  csicfb_out_if.source out_o
);

  csicfb_pkg::cfg_t       cfg_q;
  csicfb_pkg::entry_t     push_entry;
  csicfb_pkg::entry_t     fifo_rd;
  csicfb_pkg::fifo_stat_t fifo_stat;
  logic                   fifo_push;
  logic                   fifo_pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.node    <= csicfb_pkg::NODE_RST;
      cfg_q.min_gap <= csicfb_pkg::GAP_RST;
      cfg_q.wrap    <= csicfb_pkg::WRAP_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        csicfb_pkg::CFG_NODE_NUMBER: cfg_q.node    <= cfg_i.data[7:0];
        csicfb_pkg::CFG_MIN_GAP_MS:  cfg_q.min_gap <= cfg_i.data;
        csicfb_pkg::CFG_SERIAL_WRAP: cfg_q.wrap    <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  csicfb_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_q),
    .stat_i (fifo_stat),
    .push_o (fifo_push),
    .entry_o(push_entry)
  );

  csicfb_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fifo_push),
    .wdata_i(push_entry),
    .pop_i  (fifo_pop),
    .rdata_o(fifo_rd),
    .stat_o (fifo_stat)
  );

  csicfb_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rdata_i(fifo_rd),
    .stat_i (fifo_stat),
    .pop_o  (fifo_pop),
    .out_o  (out_o)
  );

  `CSICFB_ASSERT_NEVER(a_push_full, fifo_push && fifo_stat.full, "push into full queue")
  `CSICFB_ASSERT_NEVER(a_stat_both, fifo_stat.full && fifo_stat.empty, "queue full and empty")
  `CSICFB_ASSERT_IMPL(a_pop_nonempty, fifo_pop, !fifo_stat.empty, "pop from empty queue")
  `CSICFB_ASSERT_IMPL(a_pop_useful, fifo_pop, fifo_rd.hdr_vld || fifo_rd.pay_vld, "empty command")

endmodule

`default_nettype wire
